// ===== hdl/frs_pkg.sv =====
// Shared constants and types for the framed receiver with sum checksum.
`timescale 1ns / 1ps

package frs_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int POS_W       = $clog2(MAX_PAYLOAD);

  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'd170;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 7'd64;
  localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT = LEN_W'(MAX_PAYLOAD);

  typedef enum logic [0:0] {
    REG_HEADER  = 1'b0,
    REG_MAX_LEN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] length;
  } emit_req_t;

endpackage

// ===== hdl/frs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module frs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/frs_parser.sv =====
// Frame parser: config registers, phase machine, payload store writes, checksum.
`timescale 1ns / 1ps

module frs_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [0:0]                    cfg_index,
  input  logic [frs_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          in_fire,
  input  logic [frs_pkg::BYTE_W-1:0]    in_rx_byte,
  output frs_pkg::store_wr_t            store_wr,
  output frs_pkg::emit_req_t            emit_req
);
  import frs_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_CHECK  = 4'b1000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] header_r;
  logic [LEN_W-1:0]  max_len_r;
  logic [LEN_W-1:0]  expected_r, expected_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  fill_inc;

  assign limit    = (max_len_r > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : max_len_r;
  assign fill_inc = fill_r + LEN_W'(1);

  always_comb begin
    phase_nxt       = phase_r;
    expected_nxt    = expected_r;
    fill_nxt        = fill_r;
    sum_nxt         = sum_r;
    store_wr.en     = 1'b0;
    store_wr.addr   = fill_r[POS_W-1:0];
    store_wr.data   = in_rx_byte;
    emit_req.start  = 1'b0;
    emit_req.length = expected_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (in_fire && in_rx_byte == header_r) begin
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (in_fire) begin
          fill_nxt     = '0;
          sum_nxt      = '0;
          expected_nxt = in_rx_byte[LEN_W-1:0];
          if (in_rx_byte > {1'b0, limit}) begin
            phase_nxt = PH_HEADER;
          end else if (in_rx_byte == '0) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (in_fire) begin
          store_wr.en = 1'b1;
          sum_nxt     = sum_r + in_rx_byte;
          fill_nxt    = fill_inc;
          if (fill_inc >= expected_r) begin
            phase_nxt = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        if (in_fire) begin
          // run is emitted only for a non-empty frame with a matching sum
          emit_req.start = (expected_r != '0) && (sum_r == in_rx_byte);
          phase_nxt      = PH_HEADER;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      expected_r <= '0;
      fill_r     <= '0;
      sum_r      <= '0;
      header_r   <= HEADER_RESET;
      max_len_r  <= MAX_LEN_RESET;
    end else begin
      phase_r    <= phase_nxt;
      expected_r <= expected_nxt;
      fill_r     <= fill_nxt;
      sum_r      <= sum_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_HEADER:  header_r  <= cfg_data;
          REG_MAX_LEN: max_len_r <= cfg_data[LEN_W-1:0];
          default:     ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/frs_emit.sv =====
// Payload run sequencer: reads the store and presents one beat per byte.
`timescale 1ns / 1ps

module frs_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  frs_pkg::emit_req_t           emit_req,
  input  logic [frs_pkg::BYTE_W-1:0]   rd_data,
  output logic                         rd_en,
  output logic [frs_pkg::POS_W-1:0]    rd_addr,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [frs_pkg::BYTE_W-1:0]   out_payload_byte,
  output logic [frs_pkg::POS_W-1:0]    out_byte_position,
  output logic [frs_pkg::LEN_W-1:0]    out_frame_length,
  output logic                         out_last_byte
);
  import frs_pkg::*;

  typedef enum logic [1:0] {
    EM_IDLE = 2'b01,
    EM_SHOW = 2'b10
  } em_state_t;

  em_state_t        state_r, state_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             last;

  assign last = ({1'b0, idx_r} == len_r - LEN_W'(1));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r + POS_W'(1);
    unique case (state_r)
      EM_IDLE: begin
        if (emit_req.start) begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          idx_nxt   = '0;
          len_nxt   = emit_req.length;
          state_nxt = EM_SHOW;
        end
      end
      EM_SHOW: begin
        if (!out_stall) begin
          if (last) begin
            state_nxt = EM_IDLE;
          end else begin
            // fetch the next byte on the same edge that takes this beat
            rd_en   = 1'b1;
            idx_nxt = idx_r + POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      idx_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
    end
  end

  assign busy              = (state_r == EM_SHOW);
  assign out_valid         = (state_r == EM_SHOW);
  assign out_payload_byte  = rd_data;
  assign out_byte_position = idx_r;
  assign out_frame_length  = len_r;
  assign out_last_byte     = last;

endmodule

// ===== hdl/frame_receiver_sum_checksum.sv =====
// Top level of the framed byte receiver with 8-bit sum checksum.
//
// Input channel: one received byte per beat (in_valid / in_stall, in_rx_byte).
// Frames are header, length, payload bytes, then the modulo-256 payload sum.
// Bytes before a header are dropped; a length above the limit aborts the frame.
// Output channel: one beat per payload byte of a frame whose sum matched,
// carrying the byte, its position, the frame length and a last marker.
// An input byte is accepted whenever in_valid is high and no run is being delivered.
// The first output beat appears in the cycle after the checksum byte is taken
// (one RAM read); further beats follow one per cycle while out_stall is low,
// each read through the single read port of the payload store.
// in_stall is high for the whole run, until the last beat is taken.
// A high out_stall holds the current beat and pauses the run.
// The user writes configuration (cfg_wr_en, cfg_index, cfg_data) only while idle; the block does not enforce it.
// Reset returns to header hunting with header 170 and limit 64; the payload
// store needs no clearing, it is only read after being written.
`timescale 1ns / 1ps

module frame_receiver_sum_checksum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [0:0]                  cfg_index,
  input  logic [frs_pkg::BYTE_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [frs_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [frs_pkg::BYTE_W-1:0]  out_payload_byte,
  output logic [frs_pkg::POS_W-1:0]   out_byte_position,
  output logic [frs_pkg::LEN_W-1:0]   out_frame_length,
  output logic                        out_last_byte
);
  import frs_pkg::*;

  store_wr_t         store_wr;
  emit_req_t         emit_req;
  logic              in_fire;
  logic              busy;
  logic              rd_en;
  logic [POS_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  frs_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .in_rx_byte (in_rx_byte),
    .store_wr   (store_wr),
    .emit_req   (emit_req)
  );

  frs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr.en),
    .wr_addr (store_wr.addr),
    .wr_data (store_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  frs_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .emit_req          (emit_req),
    .rd_data           (rd_data),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_byte_position (out_byte_position),
    .out_frame_length  (out_frame_length),
    .out_last_byte     (out_last_byte)
  );

  a_no_input_during_run: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |-> in_stall
  ) else $error("input accepted while a run is delivered");

  a_no_store_write_during_run: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |-> !store_wr.en
  ) else $error("payload store written during a run");

  a_position_in_frame: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_byte_position} < out_frame_length)
  ) else $error("beat position beyond frame length");

  a_run_advances: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_byte) |=>
      (out_valid && out_byte_position == $past(out_byte_position) + POS_W'(1))
  ) else $error("run did not advance to the next byte");

  a_run_ends: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_byte) |=> !out_valid
  ) else $error("beat presented after the last byte");

endmodule
